### rtl/svs_pkg.sv
// Shared types and fixed field widths for the variance / standard deviation block.
package svs_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COUNT_W    = 11;
   localparam int TOTAL_W    = 26;
   localparam int VAR_W      = 38;
   localparam int SD_W       = 23;
   localparam int FRAC_BITS  = 8;
   localparam int RSP_DATA_W = 104;

   typedef enum logic [2:0] {
      CALC_IDLE,
      CALC_MUL_NQ,
      CALC_MUL_SS,
      CALC_SUB,
      CALC_MUL_NN,
      CALC_DIV,
      CALC_SQRT,
      CALC_DONE
   } calc_state_type;

endpackage

### rtl/sum_variance_stddev.sv
// A sample that does not close a set is absorbed into the running sums; ready stays high.
// A closing sample starts the sequencer: multiplies, subtraction, division and square root
// run on the shared add/subtract unit until the result enters the output register.
// Throughput: one sample per cycle inside a set; the sequencer holds req_tready low while
// it works after each set, and longer while the output register is still full.
// Synchronous active-high reset clears the running sums, the sequencer and the output valid.
module sum_variance_stddev import svs_pkg::*; #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [15:0] sample
   input  logic                  req_tlast,   // last sample of the set
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [10:0] sample_count, [36:11] total,
                                              // [74:37] spread_squared, [97:75] spread,
                                              // [103:98] zero
);

   // Only the low SAMPLE_BITS of a sample count; the port carries at most 16.
   localparam int USED_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = USED_W + CNT_W;
   localparam int SQ_W   = 2 * USED_W + CNT_W;
   localparam int Q_W    = SQ_W + CNT_W + 2 * FRAC_BITS;
   localparam int R_W    = (Q_W + 1) / 2;

   logic             take;
   logic             close;
   logic [CNT_W-1:0] set_count;
   logic [SUM_W-1:0] set_sum;
   logic [SQ_W-1:0]  set_sq;

   logic             calc_idle, calc_done, out_ack;
   logic [CNT_W-1:0] n_res;
   logic [SUM_W-1:0] sum_res;
   logic [Q_W-1:0]   var_res;   // variance with 16 fractional bits
   logic [R_W-1:0]   sd_res;    // root of that: 8 fractional bits

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Accept samples only while the sequencer is free.
   assign req_tready = calc_idle;
   assign take       = req_tvalid & req_tready;

   svs_accum #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .USED_W      (USED_W),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W),
      .SQ_W        (SQ_W)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .sample    (req_tdata),
      .last      (req_tlast),
      .close     (close),
      .set_count (set_count),
      .set_sum   (set_sum),
      .set_sq    (set_sq)
   );

   svs_calc #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W),
      .SQ_W  (SQ_W)
   ) u_calc (
      .clock     (clock),
      .reset     (reset),
      .start     (close),
      .set_count (set_count),
      .set_sum   (set_sum),
      .set_sq    (set_sq),
      .ack       (out_ack),
      .idle      (calc_idle),
      .done      (calc_done),
      .n_out     (n_res),
      .sum_out   (sum_res),
      .var_out   (var_res),
      .sd_out    (sd_res)
   );

   // Output register frees up when empty or when the downstream takes the transaction.
   assign out_ack = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (calc_done && out_ack) begin
         rsp_valid_in = 1'b1;
         // drop 8 of the 16 fractional variance bits: floor(floor(x*2^16)/2^8) = floor(x*2^8)
         rsp_data_in  = RSP_DATA_W'({SD_W'(sd_res),
                                     VAR_W'(var_res >> FRAC_BITS),
                                     TOTAL_W'(sum_res),
                                     COUNT_W'(n_res)});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/svs_addsub.sv
// Shared adder/subtractor with borrow flag, reused by every step of the sequencer.
module svs_addsub import svs_pkg::*; #(
   parameter int W = 54
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic         sub,
   output logic [W-1:0] y,
   output logic         borrow
);

   logic [W:0] diff;
   logic [W:0] total;

   assign diff   = {1'b0, a} - {1'b0, b};
   assign total  = {1'b0, a} + {1'b0, b};
   assign y      = sub ? diff[W-1:0] : total[W-1:0];
   assign borrow = sub & diff[W];

endmodule

### rtl/svs_accum.sv
// Running count, sum and sum of squares; flags the sample that closes a set.
module svs_accum import svs_pkg::*; #(
   parameter int MAX_SAMPLES = 1024,
   parameter int USED_W      = 16,
   parameter int CNT_W       = 11,
   parameter int SUM_W       = 26,
   parameter int SQ_W        = 43
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic                last,
   output logic                close,
   output logic [CNT_W-1:0]    set_count,
   output logic [SUM_W-1:0]    set_sum,
   output logic [SQ_W-1:0]     set_sq
);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [USED_W-1:0]   s;
   logic [2*USED_W-1:0] s_sq;

   assign s    = sample[USED_W-1:0];
   assign s_sq = s * s;

   always_comb begin
      count_in = count_ff + CNT_W'(1);
      sum_in   = sum_ff + SUM_W'(s);
      sq_in    = sq_ff + SQ_W'(s_sq);
   end

   assign close     = take & (last | (count_in == CNT_W'(MAX_SAMPLES)));
   assign set_count = count_in;
   assign set_sum   = sum_in;
   assign set_sq    = sq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
      end else if (take) begin
         // clear on a closing sample so the next set starts from zero
         count_ff <= close ? '0 : count_in;
         sum_ff   <= close ? '0 : sum_in;
         sq_ff    <= close ? '0 : sq_in;
      end
   end

endmodule

### rtl/svs_calc.sv
// Sequencer for the closing arithmetic: shift-add multiplies, long division, square root.
module svs_calc import svs_pkg::*; #(
   parameter int CNT_W = 11,
   parameter int SUM_W = 26,
   parameter int SQ_W  = 43
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] set_count,
   input  logic [SUM_W-1:0] set_sum,
   input  logic [SQ_W-1:0]  set_sq,
   input  logic             ack,
   output logic             idle,
   output logic             done,
   output logic [CNT_W-1:0] n_out,
   output logic [SUM_W-1:0] sum_out,
   output logic [SQ_W+CNT_W+2*FRAC_BITS-1:0] var_out,
   output logic [(SQ_W+CNT_W+2*FRAC_BITS+1)/2-1:0] sd_out
);

   localparam int D_W    = SQ_W + CNT_W;
   localparam int NN_W   = 2 * CNT_W;
   localparam int Q_W    = D_W + 2 * FRAC_BITS;
   localparam int R_W    = (Q_W + 1) / 2;
   localparam int XS_W   = 2 * R_W;
   localparam int UNIT_A = (D_W > NN_W + 1) ? D_W : NN_W + 1;
   localparam int UNIT_W = (UNIT_A > R_W + 3) ? UNIT_A : R_W + 3;
   localparam int CW     = $clog2(Q_W);

   calc_state_type state_ff, state_in;

   logic [CNT_W-1:0]  n_ff, n_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [D_W-1:0]    acc_ff, acc_in;
   logic [D_W-1:0]    nsq_ff, nsq_in;
   logic [NN_W-1:0]   nn_ff, nn_in;
   logic [SUM_W-1:0]  my_ff, my_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [UNIT_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]    dq_ff, dq_in;
   logic [XS_W-1:0]   xs_ff, xs_in;
   logic [R_W-1:0]    root_ff, root_in;

   logic [UNIT_W-1:0] op_a, op_b, unit_y;
   logic              op_sub, borrow;
   logic [UNIT_W-1:0] mul_x;
   logic [UNIT_W-1:0] div_shift, sqrt_shift;
   logic              last_step;

   svs_addsub #(.W(UNIT_W)) u_addsub (
      .a      (op_a),
      .b      (op_b),
      .sub    (op_sub),
      .y      (unit_y),
      .borrow (borrow)
   );

   assign last_step  = (cnt_ff == '0);
   assign div_shift  = {rem_ff[UNIT_W-2:0], dq_ff[Q_W-1]};
   assign sqrt_shift = {rem_ff[UNIT_W-3:0], xs_ff[XS_W-1 -: 2]};

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      acc_in   = acc_ff;
      nsq_in   = nsq_ff;
      nn_in    = nn_ff;
      my_in    = my_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      xs_in    = xs_ff;
      root_in  = root_ff;
      op_a     = '0;
      op_b     = '0;
      op_sub   = 1'b0;

      unique case (state_ff)
         CALC_MUL_NQ: mul_x = UNIT_W'(sq_ff);
         CALC_MUL_NN: mul_x = UNIT_W'(n_ff);
         default:     mul_x = UNIT_W'(sum_ff);
      endcase

      unique case (state_ff)
         CALC_IDLE: begin
            if (start) begin
               n_in     = set_count;
               sum_in   = set_sum;
               sq_in    = set_sq;
               acc_in   = '0;
               my_in    = {set_count, {(SUM_W-CNT_W){1'b0}}};
               cnt_in   = CW'(CNT_W - 1);
               state_in = CALC_MUL_NQ;
            end
         end
         CALC_MUL_NQ, CALC_MUL_SS, CALC_MUL_NN: begin
            // MSB-first shift-add: acc = 2*acc + bit*x
            op_a   = UNIT_W'({acc_ff, 1'b0});
            op_b   = my_ff[SUM_W-1] ? mul_x : '0;
            acc_in = D_W'(unit_y);
            my_in  = {my_ff[SUM_W-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
            if (last_step) begin
               priority if (state_ff == CALC_MUL_NQ) begin
                  nsq_in   = D_W'(unit_y);
                  acc_in   = '0;
                  my_in    = sum_ff;
                  cnt_in   = CW'(SUM_W - 1);
                  state_in = CALC_MUL_SS;
               end else if (state_ff == CALC_MUL_SS) begin
                  state_in = CALC_SUB;
               end else begin
                  nn_in    = NN_W'(unit_y);
                  rem_in   = '0;
                  cnt_in   = CW'(Q_W - 1);
                  state_in = CALC_DIV;
               end
            end
         end
         CALC_SUB: begin
            // n*sumsq - sum^2, scaled by 2^16 for the division
            op_a     = UNIT_W'(nsq_ff);
            op_b     = UNIT_W'(acc_ff);
            op_sub   = 1'b1;
            dq_in    = {D_W'(unit_y), {(2*FRAC_BITS){1'b0}}};
            acc_in   = '0;
            my_in    = {n_ff, {(SUM_W-CNT_W){1'b0}}};
            cnt_in   = CW'(CNT_W - 1);
            state_in = CALC_MUL_NN;
         end
         CALC_DIV: begin
            // restoring division; quotient bits shift in where dividend bits leave
            op_a   = div_shift;
            op_b   = UNIT_W'(nn_ff);
            op_sub = 1'b1;
            rem_in = borrow ? div_shift : unit_y;
            dq_in  = {dq_ff[Q_W-2:0], ~borrow};
            cnt_in = cnt_ff - CW'(1);
            if (last_step) begin
               xs_in    = XS_W'({dq_ff[Q_W-2:0], ~borrow});
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = CW'(R_W - 1);
               state_in = CALC_SQRT;
            end
         end
         CALC_SQRT: begin
            // one root bit per step: trial = 4*root + 1
            op_a    = sqrt_shift;
            op_b    = UNIT_W'({root_ff, 2'b01});
            op_sub  = 1'b1;
            rem_in  = borrow ? sqrt_shift : unit_y;
            root_in = {root_ff[R_W-2:0], ~borrow};
            xs_in   = {xs_ff[XS_W-3:0], 2'b00};
            cnt_in  = cnt_ff - CW'(1);
            if (last_step) begin
               state_in = CALC_DONE;
            end
         end
         CALC_DONE: begin
            if (ack) begin
               state_in = CALC_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CALC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      sum_ff  <= sum_in;
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      nsq_ff  <= nsq_in;
      nn_ff   <= nn_in;
      my_ff   <= my_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dq_ff   <= dq_in;
      xs_ff   <= xs_in;
      root_ff <= root_in;
   end

   assign idle    = (state_ff == CALC_IDLE);
   assign done    = (state_ff == CALC_DONE);
   assign n_out   = n_ff;
   assign sum_out = sum_ff;
   assign var_out = dq_ff;
   assign sd_out  = root_ff;

`ifndef SYNTHESIS
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == CALC_IDLE)
      else $error("set closed while calculation busy");

   a_diff_nonneg: assert property (@(posedge clock) disable iff (reset)
      state_ff == CALC_SUB |-> !borrow)
      else $error("n*sumsq - sum^2 went negative");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == CALC_DIV |-> nn_ff != '0)
      else $error("division by zero n^2");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == CALC_DONE && !ack |=> state_ff == CALC_DONE)
      else $error("result dropped before output register took it");
`endif

endmodule

### bench/sum_variance_stddev_test.sv
// Self-checking testbench for the streaming population variance / standard deviation block.
`timescale 1ns / 1ps

module sum_variance_stddev_test;
   import svs_pkg::*;

   // Generous timeout: a run made only of one-sample sets, each waiting out the
   // full solve plus receiver stalls, stays well below this limit.
   localparam int CYCLE_LIMIT      = 2_000_000;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES     = 400;
   localparam int REPORT_LIMIT     = 10;
   localparam int FULL_SET         = 1024;

   // One finished set as it travels on rsp_tdata (packed, lowest field last).
   typedef struct packed {
      logic [5:0]         pad;
      logic [SD_W-1:0]    spread;
      logic [VAR_W-1:0]   spread_squared;
      logic [TOTAL_W-1:0] total;
      logic [COUNT_W-1:0] sample_count;
   } set_stats_type;

   // Directed row: one sample plus, where it is obvious, the result it closes.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_val;
      logic                close_mark;
      logic                typed;
      logic [COUNT_W-1:0]  count;
      logic [TOTAL_W-1:0]  total;
      logic [VAR_W-1:0]    spread_squared;
      logic [SD_W-1:0]     spread;
   } directed_row_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_NARROW,
      FILL_EXTREME,
      FILL_CONSTANT
   } fill_kind_type;

   localparam int DIRECTED_ROWS = 18;
   localparam directed_row_type DIRECTED_SCRIPT [DIRECTED_ROWS] = '{
      // sets of one: no spread at all
      '{16'hFFFF, 1'b1, 1'b1, 11'd1, 26'd65535, 38'd0, 23'd0},
      '{16'h0000, 1'b1, 1'b1, 11'd1, 26'd0,     38'd0, 23'd0},
      // widest pair: variance 65535^2/4, deviation 65535/2
      '{16'h0000, 1'b0, 1'b0, 11'd0, 26'd0,     38'd0, 23'd0},
      '{16'hFFFF, 1'b1, 1'b1, 11'd2, 26'd65535, 38'd274869518400, 23'd8388480},
      // largest equal pair
      '{16'hFFFF, 1'b0, 1'b0, 11'd0, 26'd0,      38'd0, 23'd0},
      '{16'hFFFF, 1'b1, 1'b1, 11'd2, 26'd131070, 38'd0, 23'd0},
      // small ramp, fractional variance
      '{16'h0001, 1'b0, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0},
      '{16'h0002, 1'b0, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0},
      '{16'h0003, 1'b0, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0},
      '{16'h0004, 1'b1, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0},
      // alternating bit patterns, then both end bits set
      '{16'hAAAA, 1'b0, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0},
      '{16'h5555, 1'b0, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0},
      '{16'h8001, 1'b1, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0},
      // mixed values, with a pair straddling the midpoint
      '{16'h0001, 1'b0, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0},
      '{16'h8000, 1'b0, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0},
      '{16'h7FFF, 1'b0, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0},
      '{16'hFFFE, 1'b0, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0},
      '{16'h1234, 1'b1, 1'b0, 11'd0, 26'd0, 38'd0, 23'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;   // [15:0] sample
   logic                  req_tlast = 1'b0; // last sample of the set
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [10:0] sample_count, [36:11] total,
                                            // [74:37] spread_squared, [97:75] spread

   // Running set state mirrored from what the block has accepted.
   longint unsigned set_count;
   longint unsigned set_sum;
   longint unsigned set_square_sum;

   set_stats_type pending_stats[$];
   int            failures;
   int            cycle_count;
   int            send_idle_pct;
   int            recv_idle_pct;
   int            long_holds_asked;
   int            long_holds_done;
   int            hold_left;

   sum_variance_stddev dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hang guard: any stuck handshake ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Truncated integer square root, two bits of the radicand per step.
   function automatic longint unsigned floor_sqrt(input longint unsigned radicand);
      longint unsigned root;
      longint unsigned remainder;
      longint unsigned trial;
      root = 0;
      remainder = 0;
      for (int i = 31; i >= 0; i--) begin
         remainder = (remainder << 2) | ((radicand >> (2 * i)) & 64'd3);
         trial = (root << 2) | 64'd1;
         if (remainder >= trial) begin
            remainder = remainder - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   // Fold one accepted sample into the set; return 1 with the set's statistics
   // when it closes the set (marked last, or the count reached the full size).
   function automatic bit absorb_sample(input logic [SAMPLE_W-1:0] sample_val,
                                        input logic close_mark,
                                        output set_stats_type stats);
      longint unsigned s;
      longint unsigned n_sq;
      longint unsigned spread_num;
      longint unsigned quot;
      longint unsigned rem;
      longint unsigned var_q8;
      longint unsigned var_q16;
      s = longint'(sample_val);
      set_count      = set_count + 1;
      set_sum        = set_sum + s;
      set_square_sum = set_square_sum + s * s;
      stats = '0;
      if (!close_mark && set_count < FULL_SET)
         return 1'b0;
      // variance = (n*Q - S^2) / n^2, kept exact as quotient and remainder
      n_sq       = set_count * set_count;
      spread_num = set_count * set_square_sum - set_sum * set_sum;
      quot       = spread_num / n_sq;
      rem        = spread_num % n_sq;
      var_q8     = quot * 256 + (rem * 256) / n_sq;
      var_q16    = quot * 65536 + (rem * 65536) / n_sq;
      stats.sample_count   = set_count[COUNT_W-1:0];
      stats.total          = set_sum[TOTAL_W-1:0];
      stats.spread_squared = var_q8[VAR_W-1:0];
      stats.spread         = SD_W'(floor_sqrt(var_q16));
      set_count      = 0;
      set_sum        = 0;
      set_square_sum = 0;
      return 1'b1;
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("[%0t] %s", $realtime, msg);
   endtask

   // Offer one sample; idle first at the configured rate, then hold it until the
   // transaction completes. Called and returns at a falling edge.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample_val, input logic close_mark,
                              input bit typed, input set_stats_type typed_stats);
      set_stats_type stats;
      bit            closed;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample_val;
      req_tlast  <= close_mark;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      closed = absorb_sample(sample_val, close_mark, stats);
      if (closed)
         pending_stats.push_back(typed ? typed_stats : stats);
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input fill_kind_type kind,
                                                      input logic [SAMPLE_W-1:0] base);
      case (kind)
         FILL_NARROW:   return base + SAMPLE_W'($urandom_range(0, 15));
         FILL_EXTREME:  return $urandom_range(0, 1) ? '1 : '0;
         FILL_CONSTANT: return base;
         default:       return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Send one set; with mark_end low it relies on the full-size forced close.
   task automatic send_set(input int size, input fill_kind_type kind, input bit mark_end);
      logic [SAMPLE_W-1:0] base;
      base = SAMPLE_W'($urandom_range(0, 65535));
      for (int i = 0; i < size; i++)
         send_sample(pick_sample(kind, base), mark_end && (i == size - 1), 1'b0, '0);
   endtask

   // Mostly short sets, a few medium and long ones, content of every kind.
   task automatic send_random_sets(input int item_goal);
      int sent;
      int size;
      int roll;
      sent = 0;
      while (sent < item_goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 70)
            size = $urandom_range(1, 8);
         else if (roll < 95)
            size = $urandom_range(9, 40);
         else
            size = $urandom_range(41, 200);
         send_set(size, fill_kind_type'($urandom_range(0, 3)), 1'b1);
         sent += size;
      end
   endtask

   // Receiver side: random back-pressure, plus one long hold-off on request.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (long_holds_done != long_holds_asked) begin
         long_holds_done++;
         hold_left = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Check every result transaction against the oldest waiting expectation.
   always @(posedge clock) begin
      set_stats_type got;
      set_stats_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_stats.size() == 0) begin
            note_failure($sformatf("unexpected result: count %0d total %0d",
                                   got.sample_count, got.total));
         end else begin
            want = pending_stats.pop_front();
            if (got.sample_count != want.sample_count || got.total != want.total ||
                got.spread_squared != want.spread_squared || got.spread != want.spread ||
                got.pad != want.pad)
               note_failure($sformatf(
                  "mismatch exp/got: count %0d/%0d total %0d/%0d var %0d/%0d sd %0d/%0d pad %0h/%0h",
                  want.sample_count, got.sample_count, want.total, got.total,
                  want.spread_squared, got.spread_squared, want.spread, got.spread,
                  want.pad, got.pad));
         end
      end
   end

   initial begin
      set_stats_type    typed_stats;
      directed_row_type row;
      set_count        = 0;
      set_sum          = 0;
      set_square_sum   = 0;
      failures         = 0;
      cycle_count      = 0;
      long_holds_asked = 0;
      long_holds_done  = 0;
      hold_left        = 0;
      send_idle_pct    = 9;
      recv_idle_pct    = 65;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed rows; typed rows carry their result, the rest go to the predictor.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED_SCRIPT[i];
         typed_stats = '0;
         typed_stats.sample_count   = row.count;
         typed_stats.total          = row.total;
         typed_stats.spread_squared = row.spread_squared;
         typed_stats.spread         = row.spread;
         send_sample(row.sample_val, row.close_mark, row.typed, typed_stats);
      end

      // Phase one: sender seldom idles, receiver often stalls.
      send_random_sets(250);

      // Phase two: the other way round.
      send_idle_pct = 65;
      recv_idle_pct = 9;
      send_random_sets(250);

      // Phase three: no idling; one long receiver hold so the block backs up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      long_holds_asked++;
      send_random_sets(300);

      // Full-size set: closes by count, last marked or not on its final sample.
      send_set(FULL_SET, $urandom_range(0, 1) ? FILL_EXTREME : FILL_RANDOM,
               $urandom_range(0, 1) != 0);
      send_random_sets(20);
      req_tvalid <= 1'b0;

      while (pending_stats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/svs_pkg.sv
rtl/svs_addsub.sv
rtl/svs_accum.sv
rtl/svs_calc.sv
rtl/sum_variance_stddev.sv
bench/sum_variance_stddev_test.sv
